### hw/rtl/sbd_pkg.sv
package sbd_pkg;

  // Fixed field widths of the item and result.
  localparam int FP_W        = 64;
  localparam int ID_W        = 16;
  localparam int IDX_W       = 8;
  localparam int LIMIT_W     = 7;
  localparam int CNT_W       = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_write;     // write zero to the fill count at the clear address
    logic accept;        // take the input item into the working registers
    logic fill_capture;  // latch the fill count read for this bucket
    logic scan_issue;    // read the next stored fingerprint of the bucket
    logic commit;        // store the fingerprint, bump the fill, load the result
  } sbd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;      // the clearing pass is at its last bucket
    logic scan_more;     // stored fingerprints remain to be read
    logic out_free;      // the result register can take a new result
  } sbd_status_t;

endpackage

### hw/rtl/sbd_ram.sv
module sbd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sbd_ctrl.sv
module sbd_ctrl
  import sbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  sbd_status_t status,
  output sbd_cmd_t    cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_FILL   = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (status.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.fill_capture = 1'b1;
        state_next       = ST_SCAN;
      end
      ST_SCAN: begin
        // The compare of the last read happens in the cycle that leaves SCAN.
        if (status.scan_more) begin
          cmd.scan_issue = 1'b1;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

### hw/rtl/sbd_datapath.sv
module sbd_datapath
  import sbd_pkg::*;
#(
  parameter int BUCKET_SELECT_BITS = 8,
  parameter int SLOTS_PER_BUCKET   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  sbd_cmd_t           cmd,
  output sbd_status_t        status,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  logic [ID_W-1:0]    doc_id,
  input  logic [FP_W-1:0]    fingerprint,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [ID_W-1:0]    doc_id_out,
  output logic               is_duplicate,
  output logic               bucket_overflow,
  output logic [IDX_W-1:0]   bucket_index
);

  localparam int BUCKET_COUNT = 1 << BUCKET_SELECT_BITS;
  localparam int FILL_W       = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int ADDR_W       = $clog2(BUCKET_COUNT * SLOTS_PER_BUCKET);
  localparam int BKT_W        = BUCKET_SELECT_BITS;

  // Adder tree: each level adds independent neighbor pairs.
  function automatic logic [CNT_W-1:0] popcount64(input logic [FP_W-1:0] v);
    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];
    for (int i = 0; i < 32; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    return {1'b0, l5[0]} + {1'b0, l5[1]};
  endfunction

  logic [LIMIT_W-1:0] limit;
  logic [BKT_W-1:0]   clr_addr;
  logic [ID_W-1:0]    id_reg;
  logic [FP_W-1:0]    fp_reg;
  logic [BKT_W-1:0]   bucket_reg;
  logic [ADDR_W-1:0]  base_reg;
  logic [FILL_W-1:0]  fill_reg;
  logic [FILL_W-1:0]  slot;
  logic               cmp_valid;
  logic               dup;

  logic [BKT_W-1:0]   bucket_in;
  logic [ADDR_W-1:0]  base_in;
  logic               full;
  logic [CNT_W-1:0]   ham_dist;

  logic               fill_we;
  logic [BKT_W-1:0]   fill_waddr;
  logic [FILL_W-1:0]  fill_wdata;
  logic [FILL_W-1:0]  fill_rdata;
  logic               st_we;
  logic [ADDR_W-1:0]  st_waddr;
  logic [ADDR_W-1:0]  st_raddr;
  logic [FP_W-1:0]    st_rdata;

  assign bucket_in = fingerprint[FP_W-1 -: BKT_W];
  assign base_in   = ADDR_W'(bucket_in) * ADDR_W'(SLOTS_PER_BUCKET);
  assign full      = (fill_reg == FILL_W'(SLOTS_PER_BUCKET));
  assign ham_dist  = popcount64(fp_reg ^ st_rdata);

  assign fill_we    = cmd.clr_write | (cmd.commit & ~full);
  assign fill_waddr = cmd.clr_write ? clr_addr : bucket_reg;
  assign fill_wdata = cmd.clr_write ? '0 : fill_reg + FILL_W'(1);

  assign st_we    = cmd.commit & ~full;
  assign st_waddr = base_reg + ADDR_W'(fill_reg);
  assign st_raddr = base_reg + ADDR_W'(slot);

  sbd_ram #(
    .WIDTH (FILL_W),
    .DEPTH (BUCKET_COUNT)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (bucket_in),
    .rdata (fill_rdata)
  );

  sbd_ram #(
    .WIDTH (FP_W),
    .DEPTH (BUCKET_COUNT * SLOTS_PER_BUCKET)
  ) u_store_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (fp_reg),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= LIMIT_RESET;
      clr_addr  <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_data;
      end
      if (cmd.clr_write) begin
        clr_addr <= clr_addr + BKT_W'(1);
      end
      cmp_valid <= cmd.scan_issue;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      id_reg     <= doc_id;
      fp_reg     <= fingerprint;
      bucket_reg <= bucket_in;
      base_reg   <= base_in;
      slot       <= '0;
      dup        <= 1'b0;
    end else begin
      if (cmd.scan_issue) begin
        slot <= slot + FILL_W'(1);
      end
      if (cmp_valid && (ham_dist <= limit)) begin
        dup <= 1'b1;
      end
    end
    if (cmd.fill_capture) begin
      fill_reg <= fill_rdata;
    end
    if (cmd.commit) begin
      doc_id_out      <= id_reg;
      is_duplicate    <= dup;
      bucket_overflow <= full;
      bucket_index    <= IDX_W'(bucket_reg);
    end
  end

  assign status.clr_done  = &clr_addr;
  assign status.scan_more = (slot < fill_reg);
  assign status.out_free  = ~out_valid | ~out_stall;

endmodule

### hw/rtl/simhash_bucket_dedup_top.sv
// Simhash near-duplicate filter. Each input item carries a document id and
// its 64-bit fingerprint; the top BUCKET_SELECT_BITS bits of the fingerprint
// pick a bucket, the fingerprint is compared against every fingerprint
// already stored in that bucket, and one result item per input item comes out
// in arrival order with the id, a duplicate flag (some stored Hamming distance
// is at or below distance_limit), an overflow flag (the bucket already held
// SLOTS_PER_BUCKET entries, so this fingerprint was not stored) and the low 8
// bits of the bucket number. The block works on one item at a time: before the
// next item is accepted, every fingerprint already in its bucket (0 to
// SLOTS_PER_BUCKET of them) is read and compared, one per cycle, from a single
// fingerprint memory port. A finished result waits in its own output register,
// so the next item is accepted while it sits there; only the final store step
// of an item waits for that register to drain. After reset the block clears
// the per-bucket fill counts, one bucket per cycle, and holds in_stall high
// until all 2^BUCKET_SELECT_BITS buckets (256 with the default setting) are
// clear. The single configuration register, distance_limit (reset 3), is
// written through the cfg channel, which is always ready; it should be
// written only while the block is idle.
module simhash_bucket_dedup_top
  import sbd_pkg::*;
#(
  parameter int BUCKET_SELECT_BITS = 8,
  parameter int SLOTS_PER_BUCKET   = 16
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration write channel: the distance_limit register.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data,
  // Input item channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ID_W-1:0]    doc_id,
  input  logic [FP_W-1:0]    fingerprint,
  // Result item channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ID_W-1:0]    doc_id_out,
  output logic               is_duplicate,
  output logic               bucket_overflow,
  output logic [IDX_W-1:0]   bucket_index
);

  sbd_cmd_t    cmd;
  sbd_status_t status;

  // The register write is a single flop update, so the channel never waits.
  assign cfg_ready = 1'b1;

  // The controller sequences clear, fill lookup, bucket scan and commit.
  sbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the two memories, the compare unit and the result
  // register.
  sbd_datapath #(
    .BUCKET_SELECT_BITS (BUCKET_SELECT_BITS),
    .SLOTS_PER_BUCKET   (SLOTS_PER_BUCKET)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_data        (cfg_data),
    .doc_id          (doc_id),
    .fingerprint     (fingerprint),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .doc_id_out      (doc_id_out),
    .is_duplicate    (is_duplicate),
    .bucket_overflow (bucket_overflow),
    .bucket_index    (bucket_index)
  );

endmodule

### hw/rtl/sbd_checker.sv
module sbd_checker
  import sbd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [LIMIT_W-1:0] cfg_data,
  input logic               in_valid,
  input logic               in_stall,
  input logic [ID_W-1:0]    doc_id,
  input logic [FP_W-1:0]    fingerprint,
  input logic               out_valid,
  input logic               out_stall,
  input logic [ID_W-1:0]    doc_id_out,
  input logic               is_duplicate,
  input logic               bucket_overflow,
  input logic [IDX_W-1:0]   bucket_index
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // The block starts its clearing pass after reset and takes no item then.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input accepted right after reset");

  // One item at a time: an accepted item blocks the input on the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while one is in work");

  // The configuration channel never holds off a write.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write held off");

endmodule

bind simhash_bucket_dedup_top sbd_checker u_sbd_checker (.*);

### dv/simhash_bucket_dedup_checker.sv
module simhash_bucket_dedup_checker
  import sbd_pkg::*;
#(
  parameter int BUCKET_SELECT_BITS = 8,
  parameter int SLOTS_PER_BUCKET   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [ID_W-1:0]    doc_id,
  input  logic [FP_W-1:0]    fingerprint,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [ID_W-1:0]    doc_id_out,
  input  logic               is_duplicate,
  input  logic               bucket_overflow,
  input  logic [IDX_W-1:0]   bucket_index,
  output int                 mismatches,
  output int                 outstanding,
  output int                 results_seen,
  output int                 dups_seen,
  output int                 overflows_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUCKET_COUNT = 1 << BUCKET_SELECT_BITS;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic             dup;
    logic             ovf;
    logic [IDX_W-1:0] bucket;
  } doc_verdict_t;

  logic [FP_W-1:0]    fp_store [BUCKET_COUNT][SLOTS_PER_BUCKET];
  int unsigned        fill_cnt [BUCKET_COUNT];
  logic [LIMIT_W-1:0] dist_limit;
  doc_verdict_t       verdicts_due [$];

  // Compares the fingerprint with every stored one of its bucket, then appends it
  // if a slot is free.
  function automatic doc_verdict_t judge_doc(input logic [ID_W-1:0] id,
                                             input logic [FP_W-1:0] fp);
    doc_verdict_t v;
    int unsigned  b;
    b = 32'(fp[FP_W-1 -: BUCKET_SELECT_BITS]);
    v.id = id;
    v.dup = 1'b0;
    v.ovf = 1'b0;
    v.bucket = IDX_W'(b);
    for (int s = 0; s < fill_cnt[b]; s++) begin
      if ($countones(fp ^ fp_store[b][s]) <= int'(dist_limit)) v.dup = 1'b1;
    end
    if (fill_cnt[b] < SLOTS_PER_BUCKET) begin
      fp_store[b][fill_cnt[b]] = fp;
      fill_cnt[b]++;
    end else begin
      v.ovf = 1'b1;
    end
    return v;
  endfunction

  task automatic flag_mismatch(input string what, input logic [FP_W-1:0] got,
                               input logic [FP_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    doc_verdict_t want;
    if (verdicts_due.size() == 0) begin
      flag_mismatch("doc_id_out of a result with no item pending", FP_W'(doc_id_out), '0);
      return;
    end
    want = verdicts_due.pop_front();
    results_seen++;
    if (want.dup) dups_seen++;
    if (want.ovf) overflows_seen++;
    if (doc_id_out !== want.id) begin
      flag_mismatch("doc_id_out", FP_W'(doc_id_out), FP_W'(want.id));
    end
    if (is_duplicate !== want.dup) begin
      flag_mismatch("is_duplicate", FP_W'(is_duplicate), FP_W'(want.dup));
    end
    if (bucket_overflow !== want.ovf) begin
      flag_mismatch("bucket_overflow", FP_W'(bucket_overflow), FP_W'(want.ovf));
    end
    if (bucket_index !== want.bucket) begin
      flag_mismatch("bucket_index", FP_W'(bucket_index), FP_W'(want.bucket));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (fill_cnt[b]) fill_cnt[b] = 0;
      dist_limit = LIMIT_RESET;
      verdicts_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) dist_limit = cfg_data;
      // Results are checked before the new item is queued, so a result that
      // comes out with the item that should cause it is still caught.
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        verdicts_due.insert(verdicts_due.size(), judge_doc(doc_id, fingerprint));
      end
    end
    outstanding <= verdicts_due.size();
  end

endmodule

### dv/simhash_bucket_dedup_top_tb.sv
module simhash_bucket_dedup_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbd_pkg::*;

  localparam int SEL_BITS       = 8;
  localparam int SLOTS          = 16;
  localparam int N_PHASES       = 7;
  localparam int PHASE_ITEMS    = 197;
  // Length of the one long hold-off of the result side.
  localparam int LONG_HOLD      = 400;
  // Cycles of quiet after the last result before a register write or the verdict.
  // This leaves a wide margin over the longest time an item can take.
  localparam int SETTLE_CYCLES  = SLOTS + 24;
  // The slowest stretch with nothing moving is the long hold-off or the clearing
  // pass after reset; the limit is several times either.
  localparam int WATCHDOG_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ID_W-1:0]    doc_id = '0;
  logic [FP_W-1:0]    fingerprint = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ID_W-1:0]    doc_id_out;
  logic               is_duplicate;
  logic               bucket_overflow;
  logic [IDX_W-1:0]   bucket_index;

  int mismatches;
  int outstanding;
  int results_seen;
  int dups_seen;
  int overflows_seen;

  // Controls shared by the item source and the result sink.
  bit quiet     = 1'b0;  // no idling on either side in the final phase
  bit hold_req  = 1'b0;  // asks the result sink for its long hold-off
  bit hold_done = 1'b0;

  // Every fingerprint sent so far; random items are often near copies of these,
  // which is what drives buckets into duplicates and overflow.
  logic [FP_W-1:0]     sent_fps [$];
  logic [SEL_BITS-1:0] hot_buckets [6];
  int                  idle_cycles = 0;

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  simhash_bucket_dedup_top #(
    .BUCKET_SELECT_BITS(SEL_BITS),
    .SLOTS_PER_BUCKET  (SLOTS)
  ) i_dut (.*);

  simhash_bucket_dedup_checker #(
    .BUCKET_SELECT_BITS(SEL_BITS),
    .SLOTS_PER_BUCKET  (SLOTS)
  ) i_checker (.*);

  // A fingerprint that falls in the given bucket, with a random tail.
  function automatic logic [FP_W-1:0] in_bucket(input logic [SEL_BITS-1:0] b);
    logic [FP_W-1:0] tail;
    tail = {$urandom, $urandom};
    return {b, tail[FP_W-SEL_BITS-1:0]};
  endfunction

  // Random item: mostly near copies of earlier fingerprints (a few bit flips,
  // usually below the bucket select bits), then fresh fingerprints in a handful
  // of hot buckets, and some fully random ones.
  task automatic make_doc(output logic [ID_W-1:0] id, output logic [FP_W-1:0] fp);
    int unsigned     pick;
    int unsigned     flips;
    logic [FP_W-1:0] mask;
    pick = $urandom_range(0, 99);
    id = ID_W'($urandom);
    if (pick < 55 && sent_fps.size() != 0) begin
      mask = '0;
      flips = $urandom_range(0, 10);
      repeat (flips) begin
        if ($urandom_range(0, 7) == 0) mask[$urandom_range(0, FP_W-1)] = 1'b1;
        else mask[$urandom_range(0, FP_W-SEL_BITS-1)] = 1'b1;
      end
      fp = sent_fps[$urandom_range(0, sent_fps.size()-1)] ^ mask;
    end else if (pick < 85) begin
      fp = in_bucket(hot_buckets[$urandom_range(0, 5)]);
    end else begin
      fp = {$urandom, $urandom};
    end
  endtask

  // Offers one item and returns in the time step of its acceptance. The valid
  // stays high into the next item unless an idle burst is drawn, in which case
  // it is lowered here, at the acceptance step of the previous item.
  task automatic push_doc(input logic [ID_W-1:0] id, input logic [FP_W-1:0] fp);
    int unsigned burst;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      burst = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (burst) @(posedge clk);
    end
    in_valid    <= 1'b1;
    doc_id      <= id;
    fingerprint <= fp;
    do @(posedge clk); while (in_stall);
    sent_fps.insert(sent_fps.size(), fp);
  endtask

  // Brings the block to rest: no item offered, every result drained, and then
  // enough cycles that nothing can still be in flight.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // The result side stalls in random bursts, and once holds off for a long
  // stretch so that the block fills up and stalls its input.
  initial begin : result_sink
    int unsigned burst;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // The run ends in failure if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, outstanding);
      $display("FAIL simhash_bucket_dedup_top");
      $finish;
    end
  end

  initial begin : stimulus
    logic [LIMIT_W-1:0] phase_limit [N_PHASES];
    logic [ID_W-1:0]    id;
    logic [FP_W-1:0]    fp;
    logic [FP_W-1:0]    first_fp;
    int                 p;
    int                 i;

    // Distance limits of the random phases: the lowest, the highest the register
    // holds, exactly 64, a few ordinary values, one random, and the reset value.
    phase_limit = '{7'd0, 7'd127, 7'd64, 7'd8, 7'd16, 7'd5, 7'd3};
    phase_limit[5] = LIMIT_W'($urandom_range(1, 12));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at the reset limit of 3. The first items hit empty buckets
    // with the extreme ids and fingerprints. Then a fingerprint exactly at the
    // limit from a stored one, one just beyond it, and an exact copy.
    push_doc('0, '0);
    push_doc('1, '1);
    push_doc(16'h0001, 64'h7);
    push_doc(16'h0002, 64'hF0);
    push_doc(16'h0003, '1);

    // A full bucket: sixteen items fill it, the next one overflows, and an exact
    // copy of the first stored fingerprint is both a duplicate and an overflow.
    first_fp = in_bucket(8'h80);
    push_doc(16'h0100, first_fp);
    for (i = 1; i < SLOTS; i++) push_doc(ID_W'(16'h0100 + i), in_bucket(8'h80));
    push_doc(16'h0200, in_bucket(8'h80));
    push_doc(16'h0201, first_fp);

    // Random phases, each under its own distance limit. The register is written
    // only once the block has gone quiet.
    for (p = 0; p < N_PHASES; p++) begin
      settle();
      write_limit(phase_limit[p]);
      quiet = (p == N_PHASES - 1);
      foreach (hot_buckets[h]) hot_buckets[h] = SEL_BITS'($urandom);
      if (p == 0) hold_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        make_doc(id, fp);
        push_doc(id, fp);
      end
    end
    settle();

    $display("Checked %0d results: %0d near duplicates and %0d bucket overflows.",
             results_seen, dups_seen, overflows_seen);
    $display("Distance limits used: 3 after reset, then 0, 127, 64, 8, 16, %0d and 3.",
             phase_limit[5]);
    if (mismatches == 0) begin
      $display("PASS simhash_bucket_dedup_top");
    end else begin
      $display("FAIL simhash_bucket_dedup_top");
    end
    $finish;
  end

endmodule
